FILE: rtl/core/rkd_pkg.sv
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared field widths and hash constants for the row key dedup indexer.
// ----------------------------------------------------------------------------
package rkd_pkg;

  // Request and result field widths
  localparam int KEY_W = 64;
  localparam int RN_W  = 11;
  localparam int DI_W  = 11;
  localparam int DC_W  = 12;

  // Set tag held beside each slot entry; a stale tag marks the slot empty
  localparam int EPOCH_W = 8;

  // Finaliser multipliers of the 64-bit mixer
  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

endpackage

FILE: rtl/core/rkd_ifs.sv
// ----------------------------------------------------------------------------
// rkd_ifs
// Valid/ready channel interfaces: row request, result and config write.
// ----------------------------------------------------------------------------
interface rkd_in_if;
  logic                     valid;
  logic                     ready;
  logic [rkd_pkg::KEY_W-1:0] key_value;
  logic                     first_row;
  modport source (output valid, key_value, first_row, input ready);
  modport sink   (input valid, key_value, first_row, output ready);
endinterface

interface rkd_out_if;
  logic                     valid;
  logic                     ready;
  logic [rkd_pkg::RN_W-1:0] row_number;
  logic [rkd_pkg::DI_W-1:0] distinct_index;
  logic                     first_seen;
  logic [rkd_pkg::DC_W-1:0] distinct_count;
  logic                     all_distinct;
  logic                     overflow;
  modport source (output valid, row_number, distinct_index, first_seen, distinct_count,
                  all_distinct, overflow, input ready);
  modport sink   (input valid, row_number, distinct_index, first_seen, distinct_count,
                  all_distinct, overflow, output ready);
endinterface

interface rkd_cfg_if;
  logic valid;
  logic ready;
  logic compare_disabled;
  modport source (output valid, compare_disabled, input ready);
  modport sink   (input valid, compare_disabled, output ready);
endinterface

FILE: rtl/core/rkd_hash.sv
// ----------------------------------------------------------------------------
// rkd_hash
// Iterative 64-bit mixer and slot reduction. One shared 32x32 multiplier
// builds each 64-bit low product from three partial products. A slot count
// that is not a power of two is reduced 16 key bits at a time, with a
// reciprocal estimate of the quotient and one correcting subtract.
// ----------------------------------------------------------------------------
module rkd_hash #(
  parameter int HASH_SLOTS = 4096,
  parameter int SLOT_W     = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rkd_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [SLOT_W-1:0]         slot
);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_MUL  = 2'd1;
  localparam logic [1:0] H_MOD  = 2'd2;
  localparam bit IS_POW2 = ((HASH_SLOTS & (HASH_SLOTS - 1)) == 0);
  // Width of one remainder step: running remainder and a 16-bit digit
  localparam int TW = SLOT_W + 16;
  // 2^TW / HASH_SLOTS, gives the quotient of a step to within one
  localparam logic [17:0] RECIP = 18'((64'd1 << TW) / 64'(HASH_SLOTS));

  logic [1:0]        st_r;
  logic              round_r;
  logic [1:0]        step_r;
  logic [63:0]       k_r;
  logic [63:0]       acc_r;
  logic [63:0]       prod_r;
  logic [1:0]        dig_r;
  logic              ph_r;
  logic [15:0]       q_r;
  logic [SLOT_W-1:0] rem_r;
  logic              done_r;
  logic [SLOT_W-1:0] slot_r;

  logic [63:0]       mconst;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       fin;
  logic [TW-1:0]     t_w;
  logic [TW+17:0]    qprod;
  logic [TW-1:0]     qm;
  logic [TW-1:0]     diff;
  logic [TW-1:0]     rem_fix;

  // Operand selection for the partial products
  always_comb begin
    mconst = round_r ? rkd_pkg::MIX_C2 : rkd_pkg::MIX_C1;
    mul_a  = (step_r == 2'd1) ? k_r[63:32] : k_r[31:0];
    mul_b  = (step_r == 2'd2) ? mconst[63:32] : mconst[31:0];
    fin    = acc_r + {prod_r[31:0], 32'd0};
    // Remainder step: quotient estimate, then subtract and correct once
    t_w     = {rem_r, k_r[63:48]};
    qprod   = (TW+18)'(t_w) * (TW+18)'(RECIP);
    qm      = TW'(q_r) * TW'(HASH_SLOTS);
    diff    = t_w - qm;
    rem_fix = (diff >= TW'(HASH_SLOTS)) ? diff - TW'(HASH_SLOTS) : diff;
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      st_r <= H_IDLE;
    end else begin
      case (st_r)
        H_IDLE: begin
          if (start) begin
            k_r     <= key ^ (key >> 33);
            round_r <= 1'b0;
            step_r  <= 2'd0;
            st_r    <= H_MUL;
          end
        end
        H_MUL: begin
          if (step_r != 2'd3) prod_r <= 64'(mul_a * mul_b);
          step_r <= step_r + 2'd1;
          if (step_r == 2'd1) acc_r <= prod_r;
          if (step_r == 2'd2) acc_r <= fin;
          if (step_r == 2'd3) begin
            k_r     <= fin ^ (fin >> 33);
            round_r <= 1'b1;
            dig_r   <= 2'd0;
            ph_r    <= 1'b0;
            rem_r   <= '0;
            if (round_r) st_r <= H_MOD;
          end
        end
        H_MOD: begin
          if (IS_POW2) begin
            slot_r <= k_r[SLOT_W-1:0];
            done_r <= 1'b1;
            st_r   <= H_IDLE;
          end else begin
            // Each 16-bit digit, most significant first: quotient estimate, then subtract
            ph_r <= ~ph_r;
            if (!ph_r) begin
              q_r <= qprod[TW+15:TW];
            end else begin
              rem_r <= rem_fix[SLOT_W-1:0];
              k_r   <= k_r << 16;
              dig_r <= dig_r + 2'd1;
              if (dig_r == 2'd3) begin
                slot_r <= rem_fix[SLOT_W-1:0];
                done_r <= 1'b1;
                st_r   <= H_IDLE;
              end
            end
          end
        end
        default: st_r <= H_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

FILE: rtl/core/rkd_key_ram.sv
// ----------------------------------------------------------------------------
// rkd_key_ram
// Key store by distinct index: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rkd_key_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 64,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/row_key_dedup_indexer.sv
// ----------------------------------------------------------------------------
// row_key_dedup_indexer
// Gives each row a dense distinct index in first-occurrence order.
// ----------------------------------------------------------------------------
// One row is worked at a time. A compare-disabled row or a row beyond
// capacity is accepted, decided and then loaded into the result. A keyed
// row is accepted and decided, then waits on the hash (the shared 32x32
// multiplier over two mixer rounds and, when HASH_SLOTS is not a power of
// two, a remainder step for each 16-bit digit), then reads and checks the
// first slot, compares the stored key when that slot is taken, does the
// same for each further linear probe, and loads the result. Slots carry a
// set tag, so starting a new set is free; after reset, and once every 255
// sets when the tag wraps, a clearing pass runs through every slot of the
// slot memory before rows are taken. The result register lets the next
// row enter while a result waits.
module row_key_dedup_indexer #(
  parameter int ROW_CAPACITY = 2048,
  parameter int KEY_BITS     = 64,
  parameter int HASH_SLOTS   = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  rkd_in_if.sink    in_chan,
  rkd_out_if.source out_chan,
  rkd_cfg_if.sink   cfg_chan
);

  localparam int SLOT_W = $clog2(HASH_SLOTS);
  localparam int IW     = $clog2(ROW_CAPACITY);
  localparam int CW     = $clog2(ROW_CAPACITY + 1);
  localparam int EW     = rkd_pkg::EPOCH_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROC  = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_SRD   = 3'd4;
  localparam logic [2:0] S_SCHK  = 3'd5;
  localparam logic [2:0] S_KCHK  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic                pend_r, pend_nxt;
  logic [SLOT_W-1:0]   clr_r, clr_nxt;
  logic [EW-1:0]       epoch_r, epoch_nxt;
  logic [CW-1:0]       rows_r, rows_nxt;
  logic [CW-1:0]       dist_r, dist_nxt;
  logic                cmp_r;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   n_r, n_nxt;
  logic [CW-1:0]       res_rn_r, res_rn_nxt;
  logic [IW-1:0]       res_di_r, res_di_nxt;
  logic                res_fs_r, res_fs_nxt;
  logic                res_ovf_r, res_ovf_nxt;
  logic                ov_r, ov_nxt;

  // Result register
  logic                  o_valid_r;
  logic [rkd_pkg::RN_W-1:0] o_rn_r;
  logic [rkd_pkg::DI_W-1:0] o_di_r;
  logic                  o_fs_r;
  logic [rkd_pkg::DC_W-1:0] o_dc_r;
  logic                  o_ad_r;
  logic                  o_ovf_r;

  // Slot memory: {set tag, distinct index}
  logic [EW+IW-1:0]  slot_mem [HASH_SLOTS];
  logic [EW+IW-1:0]  slot_rd_r;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_addr;
  logic [EW+IW-1:0]  slot_wd;

  logic              key_we;
  logic [KEY_BITS-1:0] key_rd;
  logic              hash_start;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_slot;
  logic              load_out;
  logic [EW-1:0]     rd_epoch;
  logic [IW-1:0]     rd_idx;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign rd_epoch = slot_rd_r[EW+IW-1:IW];
  assign rd_idx   = slot_rd_r[IW-1:0];

  rkd_hash #(
    .HASH_SLOTS (HASH_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (rkd_pkg::KEY_W'(key_r)),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  rkd_key_ram #(
    .DEPTH (ROW_CAPACITY),
    .WIDTH (KEY_BITS),
    .AW    (IW)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (IW'(dist_r)),
    .wdata (key_r),
    .raddr (rd_idx),
    .rdata (key_rd)
  );

  // Control sequencer
  always_comb begin
    state_nxt   = state_r;
    pend_nxt    = pend_r;
    clr_nxt     = clr_r;
    epoch_nxt   = epoch_r;
    rows_nxt    = rows_r;
    dist_nxt    = dist_r;
    key_nxt     = key_r;
    slot_nxt    = slot_r;
    n_nxt       = n_r;
    res_rn_nxt  = res_rn_r;
    res_di_nxt  = res_di_r;
    res_fs_nxt  = res_fs_r;
    res_ovf_nxt = res_ovf_r;
    ov_nxt      = ov_r;
    slot_we     = 1'b0;
    slot_addr   = slot_r;
    slot_wd     = {epoch_r, IW'(dist_r)};
    key_we      = 1'b0;
    hash_start  = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        slot_we   = 1'b1;
        slot_addr = clr_r;
        slot_wd   = '0;
        clr_nxt   = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(HASH_SLOTS - 1)) begin
          clr_nxt   = '0;
          state_nxt = pend_r ? S_PROC : S_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          key_nxt   = in_chan.key_value[KEY_BITS-1:0];
          state_nxt = S_PROC;
          if (in_chan.first_row) begin
            rows_nxt = '0;
            dist_nxt = '0;
            if (epoch_r == '1) begin
              // Tag wrap: sweep stale tags before the row goes on
              epoch_nxt = EW'(1);
              pend_nxt  = 1'b1;
              state_nxt = S_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EW'(1);
            end
          end
        end
      end
      S_PROC: begin
        res_rn_nxt  = rows_r;
        res_di_nxt  = IW'(dist_r);
        res_fs_nxt  = 1'b1;
        res_ovf_nxt = 1'b0;
        if (rows_r >= CW'(ROW_CAPACITY)) begin
          res_ovf_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else if (cmp_r) begin
          dist_nxt  = dist_r + CW'(1);
          rows_nxt  = rows_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          hash_start = 1'b1;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          slot_nxt  = hash_slot;
          n_nxt     = '0;
          state_nxt = S_SRD;
        end
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        if (rd_epoch != epoch_r) begin
          // Empty slot: insert the new key
          slot_we   = 1'b1;
          key_we    = 1'b1;
          dist_nxt  = dist_r + CW'(1);
          rows_nxt  = rows_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_KCHK;
        end
      end
      S_KCHK: begin
        if (key_rd == key_r) begin
          res_di_nxt = rd_idx;
          res_fs_nxt = 1'b0;
          rows_nxt   = rows_r + CW'(1);
          state_nxt  = S_DONE;
        end else if (n_r == SLOT_W'(HASH_SLOTS - 1)) begin
          // Table full
          res_ovf_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          n_nxt     = n_r + SLOT_W'(1);
          slot_nxt  = (slot_r == SLOT_W'(HASH_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
          state_nxt = S_SRD;
        end
      end
      S_DONE: begin
        if (!o_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ov_nxt = res_ovf_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pend_r  <= 1'b0;
      clr_r   <= '0;
      epoch_r <= EW'(1);
      rows_r  <= '0;
      dist_r  <= '0;
      cmp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      clr_r   <= clr_nxt;
      epoch_r <= epoch_nxt;
      rows_r  <= rows_nxt;
      dist_r  <= dist_nxt;
      if (cfg_chan.valid) cmp_r <= cfg_chan.compare_disabled;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    slot_r    <= slot_nxt;
    n_r       <= n_nxt;
    res_rn_r  <= res_rn_nxt;
    res_di_r  <= res_di_nxt;
    res_fs_r  <= res_fs_nxt;
    res_ovf_r <= res_ovf_nxt;
    ov_r      <= ov_nxt;
  end

  // Slot memory, registered read
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_addr] <= slot_wd;
    slot_rd_r <= slot_mem[slot_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (load_out) begin
      o_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      o_valid_r <= 1'b0;
    end
    if (load_out) begin
      o_rn_r  <= ov_r ? '0 : rkd_pkg::RN_W'(res_rn_r);
      o_di_r  <= ov_r ? '0 : rkd_pkg::DI_W'(res_di_r);
      o_fs_r  <= ov_r ? 1'b0 : res_fs_r;
      o_dc_r  <= rkd_pkg::DC_W'(dist_r);
      o_ad_r  <= (dist_r == rows_r);
      o_ovf_r <= ov_r;
    end
  end

  assign out_chan.valid          = o_valid_r;
  assign out_chan.row_number     = o_rn_r;
  assign out_chan.distinct_index = o_di_r;
  assign out_chan.first_seen     = o_fs_r;
  assign out_chan.distinct_count = o_dc_r;
  assign out_chan.all_distinct   = o_ad_r;
  assign out_chan.overflow       = o_ovf_r;

endmodule
